>>> hdl/dtsc_pkg.sv
// Shared types and constants for the debounced trigger shot counter.
package dtsc_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int SHOT_W = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TICKS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MACHINE_ENABLE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IGNORE_GUN     = 2'd2;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd500;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_SET  = 1'b1;

    typedef struct packed {
        logic              func;
        logic              gun_pin;
        logic              button_zero;
        logic              invincible;
        logic [SHOT_W-1:0] shot_count;
    } in_item_t;

    typedef struct packed {
        logic              fire;
        logic              click;
        logic              reload_cancel;
        logic [SHOT_W-1:0] shots_remaining;
    } out_item_t;

    typedef struct packed {
        logic [15:0] debounce_ticks;
        logic        machine_enable;
        logic        ignore_gun;
    } cfg_t;

endpackage

>>> hdl/dtsc_fsm.sv
// Debounce state machine, debounce counter and shot count, updated once per transfer.
module dtsc_fsm #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dtsc_pkg::cfg_t       cfg,
    input  logic                 item_accept,
    input  dtsc_pkg::in_item_t   item,
    output dtsc_pkg::out_item_t  result
);

    typedef enum logic [2:0] {
        ST_INIT        = 3'd0,
        ST_WAIT        = 3'd1,
        ST_DB_PRESS    = 3'd2,
        ST_PULLED      = 3'd3,
        ST_DB_RELEASE  = 3'd4,
        ST_RELEASED    = 3'd5
    } state_t;

    state_t                          state_reg, state_next;
    logic [COUNT_WIDTH-1:0]          count_reg, count_next;
    logic [dtsc_pkg::SHOT_W-1:0]     shots_reg, shots_next;
    logic [31:0]                     ticks_wide;
    logic [COUNT_WIDTH-1:0]          ticks_cmp;
    logic                            pressed;
    logic                            done;
    logic                            fire, click, cancel;

    // The tick setting is compared after truncation or zero extension to the counter width.
    assign ticks_wide = {16'd0, cfg.debounce_ticks};
    assign ticks_cmp  = ticks_wide[COUNT_WIDTH-1:0];
    assign pressed    = (item.gun_pin && !cfg.ignore_gun) || item.button_zero;
    assign done       = (count_reg == ticks_cmp);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        shots_next = shots_reg;
        fire       = 1'b0;
        click      = 1'b0;
        cancel     = 1'b0;
        if (item.func == dtsc_pkg::FUNC_SET) begin
            shots_next = item.shot_count;
        end else if (cfg.machine_enable) begin
            unique case (state_reg)
                ST_WAIT: begin
                    if (pressed && !item.invincible) begin
                        if (shots_reg != '0) begin
                            state_next = ST_DB_PRESS;
                            count_next = '0;
                        end else begin
                            click = 1'b1;
                        end
                    end
                end
                ST_DB_PRESS: begin
                    if (done) begin
                        state_next = ST_PULLED;
                        count_next = '0;
                        fire       = 1'b1;
                        if (shots_reg != '0) begin
                            shots_next = shots_reg - 1'b1;
                        end
                    end else if (!pressed) begin
                        state_next = ST_WAIT;
                        count_next = '0;
                    end
                end
                ST_PULLED: begin
                    if (!pressed) begin
                        state_next = ST_DB_RELEASE;
                        count_next = '0;
                        cancel     = 1'b1;
                    end
                end
                ST_DB_RELEASE: begin
                    if (done) begin
                        state_next = ST_RELEASED;
                        count_next = '0;
                    end else if (pressed) begin
                        state_next = ST_PULLED;
                        count_next = '0;
                    end
                end
                default: begin
                    // Init, released and the unused codes all fall back to waiting.
                    state_next = ST_WAIT;
                end
            endcase
            if (state_next == ST_DB_PRESS || state_next == ST_DB_RELEASE) begin
                count_next = count_next + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            count_reg <= '0;
            shots_reg <= '0;
        end else if (item_accept) begin
            state_reg <= state_next;
            count_reg <= count_next;
            shots_reg <= shots_next;
        end
    end

    assign result.fire            = fire;
    assign result.click           = click;
    assign result.reload_cancel   = cancel;
    assign result.shots_remaining = shots_next;

endmodule

>>> hdl/dtsc_out_buf.sv
// Two-entry output buffer: a main register and a skid register for results.
module dtsc_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  dtsc_pkg::out_item_t  push_data,
    output logic                 space,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dtsc_pkg::out_item_t  m_data
);

    dtsc_pkg::out_item_t main_reg, skid_reg;
    logic                main_valid_reg, skid_valid_reg;
    logic                pop;

    assign pop     = main_valid_reg && m_ready;
    assign space   = !skid_valid_reg;
    assign m_valid = main_valid_reg;
    assign m_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // No new result can arrive while the skid register is full.
            if (pop) begin
                main_reg       <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (main_valid_reg) begin
            if (push && pop) begin
                main_reg <= push_data;
            end else if (push) begin
                skid_reg       <= push_data;
                skid_valid_reg <= 1'b1;
            end else if (pop) begin
                main_valid_reg <= 1'b0;
            end
        end else if (push) begin
            main_reg       <= push_data;
            main_valid_reg <= 1'b1;
        end
    end

endmodule

>>> hdl/debounced_trigger_shot_counter.sv
// Top level of the debounced trigger shot counter: configuration registers and block wiring.
// The block takes one item per clock: a tick with the sampled gun pin, button and invincibility
// flag, or a new shot count. Each accepted transfer pushes exactly one result into the output buffer,
// carrying the fire, click and reload-cancel pulses and the remaining shot count. The state
// machine, debounce counter and shot count update in the cycle the item is taken, so items may
// follow back to back at one per cycle; a two-entry output buffer keeps the input open while one
// result waits for the consumer, and the input stalls only when both entries are full. Write the
// configuration registers only while no results are outstanding.
module debounced_trigger_shot_counter #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  dtsc_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output dtsc_pkg::out_item_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [dtsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dtsc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    dtsc_pkg::cfg_t      cfg_reg;
    dtsc_pkg::out_item_t result;
    logic                item_accept;

    assign item_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks <= dtsc_pkg::DEBOUNCE_RESET;
            cfg_reg.machine_enable <= 1'b0;
            cfg_reg.ignore_gun     <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                dtsc_pkg::CFG_DEBOUNCE_TICKS: cfg_reg.debounce_ticks <= cfg_wdata;
                dtsc_pkg::CFG_MACHINE_ENABLE: cfg_reg.machine_enable <= cfg_wdata[0];
                dtsc_pkg::CFG_IGNORE_GUN:     cfg_reg.ignore_gun     <= cfg_wdata[0];
                default: begin
                    // Writes to unmapped indexes are dropped.
                end
            endcase
        end
    end

    dtsc_fsm #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .item_accept (item_accept),
        .item        (s_data),
        .result      (result)
    );

    dtsc_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (item_accept),
        .push_data (result),
        .space     (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef SYNTHESIS
    a_no_fire_and_click: assert property (@(posedge aclk) disable iff (!aresetn)
        item_accept |-> !(result.fire && result.click))
        else $error("fire and click raised for the same item");

    a_disabled_tick_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_accept && s_data.func == dtsc_pkg::FUNC_TICK && !cfg_reg.machine_enable)
            |-> !(result.fire || result.click || result.reload_cancel))
        else $error("pulse produced while the machine is disabled");

    a_set_loads_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_accept && s_data.func == dtsc_pkg::FUNC_SET)
            |=> (m_valid && $past(result.shots_remaining) == $past(s_data.shot_count)))
        else $error("set transfer did not load the shot count");

    a_stall_means_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");
`endif

endmodule

>>> tb/debounced_trigger_shot_counter_tb.sv
// Testbench for the debounced trigger shot counter: queued stimulus, random idling, scoreboard.
module debounced_trigger_shot_counter_tb;

    localparam int CLK_HALF = 10;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 250;
    localparam int ACTIVE_TARGET = 1500;
    localparam int SETTLE_PAUSE = 3;
    localparam int ZERO_HOLD = 40;
    localparam int SHOT_W = dtsc_pkg::SHOT_W;

    typedef enum logic [2:0] {
        TRG_INIT       = 3'd0,
        TRG_WAIT       = 3'd1,
        TRG_DB_PRESS   = 3'd2,
        TRG_PULLED     = 3'd3,
        TRG_DB_RELEASE = 3'd4,
        TRG_RELEASED   = 3'd5
    } trig_state_e;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    dtsc_pkg::in_item_t               s_data = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    dtsc_pkg::out_item_t              m_data;
    logic                             cfg_wr_en = 1'b0;
    logic [dtsc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [dtsc_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    dtsc_pkg::in_item_t  pending_items[$];
    dtsc_pkg::out_item_t expected_results[$];

    // Predicted state of the trigger machine and its register copies.
    trig_state_e       trig_st = TRG_INIT;
    logic [15:0]       db_cnt = '0;
    logic [SHOT_W-1:0] shots = '0;
    logic [15:0]       cfg_debounce = dtsc_pkg::DEBOUNCE_RESET;
    logic              cfg_enable = 1'b0;
    logic              cfg_ignore = 1'b0;

    int gap_left = 0;
    int stall_left = 0;
    int fail_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int fires_seen = 0;
    int clicks_seen = 0;
    int cancels_seen = 0;
    int reg_writes = 0;
    int active_items = 0;
    int cycle_count = 0;

    debounced_trigger_shot_counter #(
        .COUNT_WIDTH(16)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic int draw_wait();
        if ($urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    // Advances the predicted machine by one accepted item and queues the result it implies.
    task automatic predict_trigger(input dtsc_pkg::in_item_t it);
        dtsc_pkg::out_item_t res;
        logic                pressed;
        logic                done;
        res = '0;
        if (it.func == dtsc_pkg::FUNC_SET) begin
            shots = it.shot_count;
        end else if (cfg_enable) begin
            pressed = (it.gun_pin && !cfg_ignore) || it.button_zero;
            done = (db_cnt == cfg_debounce);
            case (trig_st)
                TRG_WAIT: begin
                    if (pressed && !it.invincible) begin
                        if (shots != '0) begin
                            trig_st = TRG_DB_PRESS;
                            db_cnt = '0;
                        end else begin
                            res.click = 1'b1;
                        end
                    end
                end
                TRG_DB_PRESS: begin
                    if (done) begin
                        trig_st = TRG_PULLED;
                        if (shots != '0) begin
                            shots = shots - 1'b1;
                        end
                        res.fire = 1'b1;
                        db_cnt = '0;
                    end else if (!pressed) begin
                        trig_st = TRG_WAIT;
                        db_cnt = '0;
                    end
                end
                TRG_PULLED: begin
                    if (!pressed) begin
                        res.reload_cancel = 1'b1;
                        trig_st = TRG_DB_RELEASE;
                        db_cnt = '0;
                    end
                end
                TRG_DB_RELEASE: begin
                    if (done) begin
                        trig_st = TRG_RELEASED;
                        db_cnt = '0;
                    end else if (pressed) begin
                        trig_st = TRG_PULLED;
                        db_cnt = '0;
                    end
                end
                default: begin
                    trig_st = TRG_WAIT;
                end
            endcase
            if (trig_st == TRG_DB_PRESS || trig_st == TRG_DB_RELEASE) begin
                db_cnt = db_cnt + 1'b1;
            end
        end
        res.shots_remaining = shots;
        expected_results.push_back(res);
    endtask

    task automatic check_result(input dtsc_pkg::out_item_t got);
        dtsc_pkg::out_item_t want;
        results_seen++;
        if (expected_results.size() == 0) begin
            $error("unexpected result: fire %0d click %0d reload_cancel %0d shots %0d",
                   got.fire, got.click, got.reload_cancel, got.shots_remaining);
            fail_count++;
        end else begin
            want = expected_results.pop_front();
            if (got.fire !== want.fire) begin
                $error("fire: expected %0d, actual %0d", want.fire, got.fire);
                fail_count++;
            end
            if (got.click !== want.click) begin
                $error("click: expected %0d, actual %0d", want.click, got.click);
                fail_count++;
            end
            if (got.reload_cancel !== want.reload_cancel) begin
                $error("reload_cancel: expected %0d, actual %0d",
                       want.reload_cancel, got.reload_cancel);
                fail_count++;
            end
            if (got.shots_remaining !== want.shots_remaining) begin
                $error("shots_remaining: expected %0d, actual %0d",
                       want.shots_remaining, got.shots_remaining);
                fail_count++;
            end
            fires_seen += want.fire;
            clicks_seen += want.click;
            cancels_seen += want.reload_cancel;
        end
    endtask

    // Input driver: one draw of idle cycles per item, valid held until the transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_trigger(s_data);
                items_sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    s_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_items.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data <= pending_items.pop_front();
                    gap_left <= draw_wait();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each transfer, then stalls ready for a drawn number of cycles.
    always @(posedge aclk) begin : result_monitor
        int wait_cycles;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else if (m_valid && m_ready) begin
            check_result(m_data);
            wait_cycles = draw_wait();
            stall_left <= wait_cycles;
            m_ready <= (wait_cycles == 0);
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_left <= 0;
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic dtsc_pkg::in_item_t tick_item(input logic gun, input logic btn,
                                                     input logic inv);
        dtsc_pkg::in_item_t it;
        it.func = dtsc_pkg::FUNC_TICK;
        it.gun_pin = gun;
        it.button_zero = btn;
        it.invincible = inv;
        it.shot_count = SHOT_W'($urandom);
        return it;
    endfunction

    function automatic dtsc_pkg::in_item_t set_item(input logic [SHOT_W-1:0] count);
        dtsc_pkg::in_item_t it;
        it.func = dtsc_pkg::FUNC_SET;
        it.gun_pin = 1'($urandom);
        it.button_zero = 1'($urandom);
        it.invincible = 1'($urandom);
        it.shot_count = count;
        return it;
    endfunction

    // Mostly tiny counts so the magazine runs dry and clicks happen often.
    function automatic logic [SHOT_W-1:0] random_shots();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            return SHOT_W'($urandom_range(0, 3));
        end else if (pick < 9) begin
            return SHOT_W'($urandom);
        end
        return '1;
    endfunction

    task automatic push_ticks(input int n, input logic gun, input logic btn, input logic inv);
        for (int k = 0; k < n; k++) begin
            pending_items.push_back(tick_item(gun, btn, inv));
        end
    endtask

    task automatic write_reg(input logic [dtsc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [dtsc_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            dtsc_pkg::CFG_DEBOUNCE_TICKS: cfg_debounce = val;
            dtsc_pkg::CFG_MACHINE_ENABLE: cfg_enable = val[0];
            dtsc_pkg::CFG_IGNORE_GUN:     cfg_ignore = val[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_PAUSE) @(posedge aclk);
    endtask

    // Released trigger for longer than the debounce window brings any state back to wait.
    task automatic settle_machine();
        push_ticks(int'(cfg_debounce) + 4, 1'b0, 1'b0, 1'b0);
        wait_idle();
    endtask

    task automatic run_random_phase();
        int          added;
        int          n;
        logic [1:0]  src;
        if (!cfg_enable) begin
            write_reg(dtsc_pkg::CFG_MACHINE_ENABLE, 16'd1);
        end
        settle_machine();
        write_reg(dtsc_pkg::CFG_DEBOUNCE_TICKS, 16'($urandom_range(1, 6)));
        write_reg(dtsc_pkg::CFG_IGNORE_GUN, 16'($urandom_range(0, 1)));
        write_reg(dtsc_pkg::CFG_MACHINE_ENABLE, 16'($urandom_range(0, 5) != 0));
        pending_items.push_back(set_item(random_shots()));
        added = 1;
        while (added < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 2) begin
                n = $urandom_range(1, 8);
                repeat (n) pending_items.push_back(dtsc_pkg::in_item_t'($urandom));
                added += n;
            end else begin
                // Press held around the debounce window, then a release of similar length.
                src = 2'($urandom_range(1, 3));
                n = $urandom_range(0, int'(cfg_debounce) + 4);
                for (int k = 0; k < n; k++) begin
                    pending_items.push_back(tick_item(src[0], src[1],
                                                      $urandom_range(0, 7) == 0));
                end
                added += n;
                if ($urandom_range(0, 9) == 0) begin
                    pending_items.push_back(set_item(random_shots()));
                    added++;
                end
                n = $urandom_range(0, int'(cfg_debounce) + 4);
                for (int k = 0; k < n; k++) begin
                    pending_items.push_back(tick_item(1'b0, 1'b0, $urandom_range(0, 7) == 0));
                end
                added += n;
            end
        end
        if (cfg_enable) begin
            active_items += added;
        end
        wait_idle();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Disabled after reset: ticks are frozen, a set still lands.
        pending_items.push_back(tick_item(1'b1, 1'b1, 1'b0));
        pending_items.push_back(set_item(16'hFFFF));
        pending_items.push_back(tick_item(1'b1, 1'b1, 1'b1));
        pending_items.push_back(tick_item(1'b0, 1'b0, 1'b0));
        wait_idle();

        // Enabled with the reset debounce: leave init, start and abort a press.
        write_reg(dtsc_pkg::CFG_MACHINE_ENABLE, 16'd1);
        pending_items.push_back(tick_item(1'b0, 1'b0, 1'b0));
        pending_items.push_back(tick_item(1'b1, 1'b0, 1'b0));
        pending_items.push_back(tick_item(1'b0, 1'b0, 1'b0));
        wait_idle();

        // Full press and release cycle, with a bounce back to pulled during the release.
        write_reg(dtsc_pkg::CFG_DEBOUNCE_TICKS, 16'd2);
        pending_items.push_back(tick_item(1'b1, 1'b0, 1'b0));
        pending_items.push_back(tick_item(1'b0, 1'b1, 1'b0));
        pending_items.push_back(tick_item(1'b1, 1'b1, 1'b0));
        pending_items.push_back(tick_item(1'b0, 1'b0, 1'b0));
        pending_items.push_back(tick_item(1'b0, 1'b1, 1'b0));
        pending_items.push_back(tick_item(1'b0, 1'b0, 1'b1));
        push_ticks(3, 1'b0, 1'b0, 1'b0);
        pending_items.push_back(tick_item(1'b1, 1'b0, 1'b1));
        // Empty magazine clicks unless invincible.
        pending_items.push_back(set_item(16'd0));
        pending_items.push_back(tick_item(1'b1, 1'b0, 1'b0));
        pending_items.push_back(tick_item(1'b0, 1'b1, 1'b0));
        pending_items.push_back(tick_item(1'b0, 1'b1, 1'b1));
        // Shots cleared while the press is being debounced still fire.
        pending_items.push_back(set_item(16'd1));
        pending_items.push_back(tick_item(1'b0, 1'b1, 1'b0));
        pending_items.push_back(set_item(16'd0));
        push_ticks(2, 1'b0, 1'b1, 1'b0);
        push_ticks(4, 1'b0, 1'b0, 1'b0);
        wait_idle();

        // With the gun pin masked only the button counts.
        write_reg(dtsc_pkg::CFG_IGNORE_GUN, 16'd1);
        pending_items.push_back(tick_item(1'b1, 1'b0, 1'b0));
        pending_items.push_back(tick_item(1'b0, 1'b1, 1'b0));
        wait_idle();
        write_reg(dtsc_pkg::CFG_IGNORE_GUN, 16'd0);

        // Zero debounce: the counter starts at one, so a short hold never reaches the match.
        write_reg(dtsc_pkg::CFG_DEBOUNCE_TICKS, 16'd0);
        pending_items.push_back(set_item(16'd3));
        push_ticks(ZERO_HOLD, 1'b1, 1'b0, 1'b0);
        push_ticks(2, 1'b0, 1'b0, 1'b0);
        wait_idle();

        write_reg(dtsc_pkg::CFG_DEBOUNCE_TICKS, 16'd2);
        settle_machine();

        // Longest debounce: press starts and is abandoned well short of the window.
        write_reg(dtsc_pkg::CFG_DEBOUNCE_TICKS, 16'hFFFF);
        push_ticks(4, 1'b0, 1'b1, 1'b0);
        push_ticks(2, 1'b0, 1'b0, 1'b0);
        wait_idle();
        write_reg(dtsc_pkg::CFG_DEBOUNCE_TICKS, 16'd2);

        while (active_items < ACTIVE_TARGET) begin
            run_random_phase();
        end
        wait_idle();

        $display("Checked %0d results from %0d input transfers over %0d register writes.",
                 results_seen, items_sent, reg_writes);
        $display("Pulses checked: %0d fire, %0d click, %0d reload cancel.",
                 fires_seen, clicks_seen, cancels_seen);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
